// ----- rtl/tbds_pkg.sv -----
// Shared constants, status codes and the divider request type for the
// thermal block downsampler. No dependencies.
`default_nettype none
package tbds_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int MAX_OUT_COLS = 64;
    localparam int MAX_OUT_ROWS = 64;

    localparam int DIM_W   = 11;
    localparam int TCOLS_W = 7;
    localparam int PIX_W   = 16;
    localparam int AVG_W   = 24;
    localparam int SUM_W   = 40;
    localparam int CNT_W   = 21;
    localparam int POS_W   = 10;
    localparam int COL_AW  = $clog2(MAX_OUT_COLS);
    localparam int ROW_AW  = $clog2(MAX_OUT_ROWS);
    localparam int CELL_AW = COL_AW + ROW_AW;
    localparam int COLM_W  = SUM_W + CNT_W;
    localparam int DIV_NW  = 48;
    localparam int DIV_DW  = 24;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;
    localparam logic [1:0] STAT_NOFRAME = 2'd2;
    localparam logic [1:0] STAT_OVF     = 2'd3;

    localparam logic [1:0] REG_SRC_WIDTH   = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_TARGET_COLS = 2'd2;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

endpackage
`default_nettype wire

// ----- rtl/tbds_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none
module tbds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/tbds_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on tbds_pkg.
`default_nettype none
module tbds_div import tbds_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire div_req_t          req,
    output logic                   done,
    output logic      [DIV_NW-1:0] quotient
);
    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dvs_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   shifted;
    logic              fits;

    assign shifted  = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits     = shifted >= {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
                cnt_reg  <= CW'(DIV_NW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (fits) begin
                    rem_reg <= DIV_DW'(shifted - {1'b0, dvs_reg});
                end else begin
                    rem_reg <= shifted[DIV_DW-1:0];
                end
                quo_reg <= {quo_reg[DIV_NW-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/thermal_block_downsample_autoscale_top.sv -----
// Channel   Dir  Contents
// s_*       in   tuser: kind; tdata[15:0]: pixel
// m_*       out  tdata: grays, column, row pair, row end; tlast: last; tuser: status
// APB       in   src_width @0x0, src_height @0x4, target_cols @0x8
// A load accepts the pixel, reads the column RAM and writes the sum back. The last
// pixel of each cell row then runs the ow cells of that row through the divider.
// A fetch does two cell RAM reads and two divisions.
// After reset and after every register write, three divisions and a clearing pass
// over all 64 column RAM entries run; s_tready is low then.
// s_tready is low while an item is being worked on; results wait in m_*.
// Depends on tbds_pkg, tbds_ram, tbds_div.
`default_nettype none
module thermal_block_downsample_autoscale_top import tbds_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] pixel
    input  wire logic        s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [7:0] top_gray, [15:8] bottom_gray,
                                        // [21:16] cell_col, [26:22] text_row,
                                        // [27] row_end, [31:28] zero
    output logic             m_tlast,   // last
    output logic      [1:0]  m_tuser,   // [1:0] status
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    localparam logic [4:0] ST_SU0     = 5'd0;
    localparam logic [4:0] ST_SU1     = 5'd1;
    localparam logic [4:0] ST_SU2     = 5'd2;
    localparam logic [4:0] ST_SU3     = 5'd3;
    localparam logic [4:0] ST_CLR     = 5'd4;
    localparam logic [4:0] ST_IDLE    = 5'd5;
    localparam logic [4:0] ST_LD_RD   = 5'd6;
    localparam logic [4:0] ST_LD_ADD  = 5'd7;
    localparam logic [4:0] ST_FIN_RD  = 5'd8;
    localparam logic [4:0] ST_FIN_DAT = 5'd9;
    localparam logic [4:0] ST_FIN_DIV = 5'd10;
    localparam logic [4:0] ST_FE_RD   = 5'd11;
    localparam logic [4:0] ST_FE_TOP  = 5'd12;
    localparam logic [4:0] ST_FE_BOT  = 5'd13;
    localparam logic [4:0] ST_FE_DIVT = 5'd14;
    localparam logic [4:0] ST_FE_DIVB = 5'd15;
    localparam logic [4:0] ST_EMIT    = 5'd16;

    logic [4:0]         state_reg;
    logic [DIM_W-1:0]   src_width_reg, src_height_reg;
    logic [TCOLS_W-1:0] target_cols_reg;
    logic [DIM_W-1:0]   step_reg, oh_reg;
    logic [TCOLS_W-1:0] ow_reg;
    logic [POS_W-1:0]   lx_reg, ly_reg, sx_reg, sy_reg, ox_reg, oy_reg;
    logic [POS_W-1:0]   fin_oy_reg;
    logic               fin_reg;
    logic [COL_AW-1:0]  acc_col_reg, fcol_reg, clr_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [AVG_W-1:0]   min_reg, max_reg, top_val_reg, bot_val_reg;
    logic               any_reg, loaded_reg;
    logic [COL_AW-1:0]  rd_ox_reg;
    logic [ROW_AW-1:0]  rd_ty_reg;
    logic [7:0]         res_top_reg, res_bot_reg;
    logic [5:0]         res_col_reg;
    logic [4:0]         res_row_reg;
    logic               res_rend_reg, res_last_reg;
    logic [1:0]         res_stat_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;
    logic               m_tlast_reg;
    logic [1:0]         m_tuser_reg;

    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [TCOLS_W-1:0] t_eff;
    logic [TCOLS_W-1:0] rows;
    logic [ROW_AW-1:0]  pairs;
    logic               flat;
    logic [AVG_W-1:0]   lo, hi, span, gray_src, diff;
    logic [DIV_NW-1:0]  gray_num;
    logic [7:0]         gray;
    logic               cfg_wr, cfg_hit;
    logic               row_done, col_wrap, in_cell, frame_start;

    div_req_t           div_req;
    logic               div_done;
    logic [DIV_NW-1:0]  div_quo;

    logic               col_we;
    logic [COL_AW-1:0]  col_waddr, col_raddr;
    logic [COLM_W-1:0]  col_wdata, col_rdata;
    logic [SUM_W-1:0]   col_sum;
    logic [CNT_W-1:0]   col_cnt;
    logic               cell_we;
    logic [CELL_AW-1:0] cell_waddr, cell_raddr;
    logic [AVG_W-1:0]   cell_wdata, cell_rdata;

    tbds_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // column sums and counts, {count, sum}
    tbds_ram #(.WIDTH(COLM_W), .DEPTH(MAX_OUT_COLS)) u_col_ram (
        .aclk  (aclk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    tbds_ram #(.WIDTH(AVG_W), .DEPTH(MAX_OUT_COLS * MAX_OUT_ROWS)) u_cell_ram (
        .aclk  (aclk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    assign col_sum = col_rdata[SUM_W-1:0];
    assign col_cnt = col_rdata[COLM_W-1:SUM_W];

    always_comb begin
        w_eff = (src_width_reg == '0) ? DIM_W'(1) :
                (src_width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : src_width_reg;
        h_eff = (src_height_reg == '0) ? DIM_W'(1) :
                (src_height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : src_height_reg;
        t_eff = (target_cols_reg == '0) ? TCOLS_W'(1) :
                (target_cols_reg > TCOLS_W'(MAX_OUT_COLS)) ? TCOLS_W'(MAX_OUT_COLS) :
                target_cols_reg;
        rows  = (oh_reg < DIM_W'(MAX_OUT_ROWS)) ? TCOLS_W'(oh_reg) : TCOLS_W'(MAX_OUT_ROWS);
        pairs = ROW_AW'(rows >> 1);
        // flat or empty frame maps onto 0..1.0
        flat  = !any_reg || !(max_reg > min_reg);
        lo    = flat ? '0 : min_reg;
        hi    = flat ? AVG_W'(256) : max_reg;
        span  = hi - lo;
        gray_src = (state_reg == ST_FE_BOT) ? top_val_reg : bot_val_reg;
        diff     = (gray_src > lo) ? gray_src - lo : '0;
        gray_num = DIV_NW'({diff, 8'd0}) - DIV_NW'(diff);
        gray     = (div_quo > DIV_NW'(255)) ? 8'd255 : div_quo[7:0];
    end

    // load position bookkeeping for the word at the input
    always_comb begin
        frame_start = (lx_reg == '0) && (ly_reg == '0);
        row_done    = (DIM_W'(lx_reg) + 1'b1) >= w_eff;
        col_wrap    = (DIM_W'(sx_reg) + 1'b1) == step_reg;
        in_cell     = (DIM_W'(ox_reg) < DIM_W'(ow_reg)) && (DIM_W'(oy_reg) < oh_reg) &&
                      (s_tdata != '0) && (s_tdata != '1);
    end

    always_comb begin
        div_req    = '0;
        col_we     = 1'b0;
        col_waddr  = acc_col_reg;
        col_wdata  = '0;
        col_raddr  = acc_col_reg;
        cell_we    = 1'b0;
        cell_waddr = {fin_oy_reg[ROW_AW-1:0], fcol_reg};
        cell_wdata = '0;
        cell_raddr = {rd_ty_reg[ROW_AW-2:0], 1'b0, rd_ox_reg};
        case (state_reg)
            ST_SU0: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_NW'(w_eff + DIM_W'(t_eff) - 1'b1);
                div_req.divisor  = DIV_DW'(t_eff);
            end
            ST_SU1: begin
                div_req.start    = div_done;
                div_req.dividend = DIV_NW'(w_eff);
                div_req.divisor  = div_quo[DIV_DW-1:0];
            end
            ST_SU2: begin
                div_req.start    = div_done;
                div_req.dividend = DIV_NW'(h_eff);
                div_req.divisor  = DIV_DW'(step_reg);
            end
            ST_CLR: begin
                col_we    = 1'b1;
                col_waddr = clr_reg;
            end
            ST_LD_ADD: begin
                col_we    = 1'b1;
                col_wdata = {col_cnt + 1'b1, col_sum + SUM_W'(pix_reg)};
            end
            ST_FIN_RD: begin
                col_raddr = fcol_reg;
            end
            ST_FIN_DAT: begin
                col_we           = 1'b1;
                col_waddr        = fcol_reg;
                div_req.start    = col_cnt != '0;
                div_req.dividend = DIV_NW'({col_sum, 8'd0});
                div_req.divisor  = DIV_DW'(col_cnt);
                // empty cell stores zero
                cell_we = (col_cnt == '0) && (fin_oy_reg < POS_W'(MAX_OUT_ROWS));
            end
            ST_FIN_DIV: begin
                cell_we    = div_done && (fin_oy_reg < POS_W'(MAX_OUT_ROWS));
                cell_wdata = div_quo[AVG_W-1:0];
            end
            ST_FE_TOP: begin
                cell_raddr = {rd_ty_reg[ROW_AW-2:0], 1'b1, rd_ox_reg};
            end
            ST_FE_BOT: begin
                div_req.start    = 1'b1;
                div_req.dividend = gray_num;
                div_req.divisor  = span;
            end
            ST_FE_DIVT: begin
                div_req.start    = div_done;
                div_req.dividend = gray_num;
                div_req.divisor  = span;
            end
            default: begin
            end
        endcase
    end

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_hit = (paddr[3:2] == REG_SRC_WIDTH) || (paddr[3:2] == REG_SRC_HEIGHT) ||
                     (paddr[3:2] == REG_TARGET_COLS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_SU0;
            src_width_reg   <= DIM_W'(320);
            src_height_reg  <= DIM_W'(240);
            target_cols_reg <= TCOLS_W'(48);
            lx_reg <= '0; ly_reg <= '0; sx_reg <= '0; sy_reg <= '0;
            ox_reg <= '0; oy_reg <= '0;
            min_reg      <= '1;
            max_reg      <= '0;
            any_reg      <= 1'b0;
            loaded_reg   <= 1'b0;
            rd_ox_reg    <= '0;
            rd_ty_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            clr_reg      <= '0;
            fcol_reg     <= '0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_SU0: state_reg <= ST_SU1;
                ST_SU1: begin
                    if (div_done) begin
                        step_reg  <= div_quo[DIM_W-1:0];
                        state_reg <= ST_SU2;
                    end
                end
                ST_SU2: begin
                    if (div_done) begin
                        ow_reg    <= div_quo[TCOLS_W-1:0];
                        state_reg <= ST_SU3;
                    end
                end
                ST_SU3: begin
                    if (div_done) begin
                        oh_reg    <= div_quo[DIM_W-1:0];
                        clr_reg   <= '0;
                        state_reg <= ST_CLR;
                    end
                end
                ST_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == COL_AW'(MAX_OUT_COLS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (!s_tuser) begin
                            if (frame_start) begin
                                min_reg    <= '1;
                                max_reg    <= '0;
                                any_reg    <= 1'b0;
                                loaded_reg <= 1'b0;
                                rd_ox_reg  <= '0;
                                rd_ty_reg  <= '0;
                            end
                            acc_col_reg <= ox_reg[COL_AW-1:0];
                            pix_reg     <= s_tdata;
                            fin_oy_reg  <= oy_reg;
                            fin_reg     <= row_done && (DIM_W'(oy_reg) < oh_reg) &&
                                           ((DIM_W'(sy_reg) + 1'b1) == step_reg);
                            fcol_reg    <= '0;
                            if (row_done) begin
                                lx_reg <= '0; sx_reg <= '0; ox_reg <= '0;
                                if ((DIM_W'(ly_reg) + 1'b1) >= h_eff) begin
                                    ly_reg <= '0; sy_reg <= '0; oy_reg <= '0;
                                    loaded_reg <= 1'b1;
                                end else begin
                                    ly_reg <= ly_reg + 1'b1;
                                    if ((DIM_W'(sy_reg) + 1'b1) == step_reg) begin
                                        sy_reg <= '0;
                                        oy_reg <= oy_reg + 1'b1;
                                    end else begin
                                        sy_reg <= sy_reg + 1'b1;
                                    end
                                end
                            end else begin
                                lx_reg <= lx_reg + 1'b1;
                                if (col_wrap) begin
                                    sx_reg <= '0;
                                    ox_reg <= ox_reg + 1'b1;
                                end else begin
                                    sx_reg <= sx_reg + 1'b1;
                                end
                            end
                            if (in_cell) begin
                                state_reg <= ST_LD_RD;
                            end else if (row_done && (DIM_W'(oy_reg) < oh_reg) &&
                                         ((DIM_W'(sy_reg) + 1'b1) == step_reg)) begin
                                state_reg <= ST_FIN_RD;
                            end
                        end else begin
                            res_top_reg  <= '0;
                            res_bot_reg  <= '0;
                            res_col_reg  <= '0;
                            res_row_reg  <= '0;
                            res_rend_reg <= 1'b0;
                            res_last_reg <= 1'b0;
                            if (!loaded_reg) begin
                                res_stat_reg <= STAT_NOFRAME;
                                state_reg    <= ST_EMIT;
                            end else if (rd_ty_reg >= pairs) begin
                                res_stat_reg <= STAT_EMPTY;
                                state_reg    <= ST_EMIT;
                            end else begin
                                res_col_reg  <= 6'(rd_ox_reg);
                                res_row_reg  <= 5'(rd_ty_reg);
                                res_rend_reg <= (TCOLS_W'(rd_ox_reg) + 1'b1) == ow_reg;
                                res_last_reg <= ((TCOLS_W'(rd_ox_reg) + 1'b1) == ow_reg) &&
                                                ((rd_ty_reg + 1'b1) == pairs);
                                res_stat_reg <= (oh_reg > DIM_W'(MAX_OUT_ROWS)) ?
                                                STAT_OVF : STAT_OK;
                                state_reg    <= ST_FE_RD;
                            end
                        end
                    end
                end
                ST_LD_RD: state_reg <= ST_LD_ADD;
                ST_LD_ADD: state_reg <= fin_reg ? ST_FIN_RD : ST_IDLE;
                ST_FIN_RD: state_reg <= ST_FIN_DAT;
                ST_FIN_DAT: begin
                    if (col_cnt != '0) begin
                        state_reg <= ST_FIN_DIV;
                    end else if ((TCOLS_W'(fcol_reg) + 1'b1) == ow_reg) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        fcol_reg  <= fcol_reg + 1'b1;
                        state_reg <= ST_FIN_RD;
                    end
                end
                ST_FIN_DIV: begin
                    if (div_done) begin
                        any_reg <= 1'b1;
                        if (div_quo[AVG_W-1:0] < min_reg) begin
                            min_reg <= div_quo[AVG_W-1:0];
                        end
                        if (div_quo[AVG_W-1:0] > max_reg) begin
                            max_reg <= div_quo[AVG_W-1:0];
                        end
                        if ((TCOLS_W'(fcol_reg) + 1'b1) == ow_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            fcol_reg  <= fcol_reg + 1'b1;
                            state_reg <= ST_FIN_RD;
                        end
                    end
                end
                ST_FE_RD: state_reg <= ST_FE_TOP;
                ST_FE_TOP: begin
                    top_val_reg <= cell_rdata;
                    state_reg   <= ST_FE_BOT;
                end
                ST_FE_BOT: begin
                    bot_val_reg <= cell_rdata;
                    state_reg   <= ST_FE_DIVT;
                end
                ST_FE_DIVT: begin
                    if (div_done) begin
                        res_top_reg <= gray;
                        state_reg   <= ST_FE_DIVB;
                    end
                end
                ST_FE_DIVB: begin
                    if (div_done) begin
                        res_bot_reg <= gray;
                        if ((TCOLS_W'(rd_ox_reg) + 1'b1) == ow_reg) begin
                            rd_ox_reg <= '0;
                            rd_ty_reg <= rd_ty_reg + 1'b1;
                        end else begin
                            rd_ox_reg <= rd_ox_reg + 1'b1;
                        end
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, res_rend_reg, res_row_reg, res_col_reg,
                                         res_bot_reg, res_top_reg};
                        m_tlast_reg  <= res_last_reg;
                        m_tuser_reg  <= res_stat_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_SU0;
            endcase
            // register write aborts the partial frame and re-derives the geometry
            if (cfg_wr && cfg_hit) begin
                case (paddr[3:2])
                    REG_SRC_WIDTH:   src_width_reg   <= pwdata[DIM_W-1:0];
                    REG_SRC_HEIGHT:  src_height_reg  <= pwdata[DIM_W-1:0];
                    REG_TARGET_COLS: target_cols_reg <= pwdata[TCOLS_W-1:0];
                    default: begin
                    end
                endcase
                lx_reg <= '0; ly_reg <= '0; sx_reg <= '0; sy_reg <= '0;
                ox_reg <= '0; oy_reg <= '0;
                loaded_reg <= 1'b0;
                state_reg  <= ST_SU0;
            end
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SRC_WIDTH:   prdata = 32'(src_width_reg);
            REG_SRC_HEIGHT:  prdata = 32'(src_height_reg);
            REG_TARGET_COLS: prdata = 32'(target_cols_reg);
            default:         prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;
endmodule
`default_nettype wire

// ----- rtl/tbds_chk.sv -----
// Port-level checks for the downsampler top, bound to it below.
// Depends on tbds_pkg and thermal_block_downsample_autoscale_top.
`default_nettype none
module tbds_chk import tbds_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [1:0]  m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
        $stable(m_tuser))
        else $error("result word changed while stalled");

    a_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_EMPTY || m_tuser == STAT_NOFRAME) |->
        m_tdata == '0 && !m_tlast)
        else $error("status-only word carries data");

    a_last_rend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[27])
        else $error("last pair not at row end");

    a_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_tready)
        else $error("input ready before geometry setup");
endmodule

bind thermal_block_downsample_autoscale_top tbds_chk u_tbds_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
